### design/value_noise_fbm_3d_assert.svh
// ----------------------------------------------------------------------------
// value_noise_fbm_3d_assert.svh
// Assertion macros for the fractal value noise block.
// ----------------------------------------------------------------------------
`ifndef VALUE_NOISE_FBM_3D_ASSERT_SVH
`define VALUE_NOISE_FBM_3D_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define VNF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vnf assertion failed");
// next-cycle implication
`define VNF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vnf assertion failed");
`else
`define VNF_ASSERT_IMP(lbl, ante, cons)
`define VNF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### design/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared codes, constants and types of the fractal value noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package vnf_pkg;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 31;

	localparam logic [CFG_AW-1:0] REG_OCTAVE_COUNT = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PERSISTENCE  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_OFFSET_X     = 3'd2;
	localparam logic [CFG_AW-1:0] REG_OFFSET_Y     = 3'd3;
	localparam logic [CFG_AW-1:0] REG_OFFSET_Z     = 3'd4;

	// datapath operations
	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_SPLIT  = 4'd2;
	localparam logic [3:0] OP_SQ     = 4'd3;
	localparam logic [3:0] OP_SMOOTH = 4'd4;
	localparam logic [3:0] OP_H0     = 4'd5;
	localparam logic [3:0] OP_H1     = 4'd6;
	localparam logic [3:0] OP_H2     = 4'd7;
	localparam logic [3:0] OP_H3     = 4'd8;
	localparam logic [3:0] OP_LERP   = 4'd9;
	localparam logic [3:0] OP_ACC    = 4'd10;
	localparam logic [3:0] OP_AMP    = 4'd11;
	localparam logic [3:0] OP_DINIT  = 4'd12;
	localparam logic [3:0] OP_DSTEP  = 4'd13;
	localparam logic [3:0] OP_OUT    = 4'd14;

	// lattice hash constants
	localparam logic [31:0] HASH_MUL_Y = 32'd57;
	localparam logic [31:0] HASH_MUL_Z = 32'd131;
	localparam logic [31:0] HASH_K1    = 32'd15731;
	localparam logic [31:0] HASH_K2    = 32'd789221;
	localparam logic [31:0] HASH_K3    = 32'd1376312589;

	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [16:0] OCT_DEFAULT = 17'd4;

	// width of the normalizing division, follows from the octave limit
	function automatic int div_width(input int max_oct);
		int ob;
		ob = (max_oct > 1) ? $clog2(max_oct) : 0;
		return 35 + ob;
	endfunction

	// controller to datapath command
	typedef struct packed {
		logic [3:0] op;
		logic [2:0] sel;    // axis, corner or blend level
		logic [3:0] shift;  // octave index
	} cmd_t;

endpackage

`default_nettype wire

### design/value_noise_fbm_3d.sv
// One item at a time over N octaves, N = octave count (1..8); a new item is taken only in idle.
// The octave steps share the single 33x33 multiplier,
// and the normalizing divide takes one quotient bit a cycle.
// The result sits in an output register, so the next item is accepted while it waits.
// Reset (arst_n low): control idle, octave count 4, persistence 0.5, offsets 0.
`default_nettype none
`include "value_noise_fbm_3d_assert.svh"

// ----------------------------------------------------------------------------
// value_noise_fbm_3d
// Fractal value noise over a 3D lattice, one point in, one value out.
// ----------------------------------------------------------------------------
module value_noise_fbm_3d #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [vnf_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire [vnf_pkg::CFG_DW-1:0]  cfg_wdata,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire [95:0]                 s_tdata,   // pos_x, pos_y, pos_z
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [23:0]                m_tdata    // noise_value, zero pad
);
	import vnf_pkg::*;

	localparam int OW = $clog2(MAX_OCTAVES+1);

	cmd_t          cmd;
	logic [OW-1:0] oct_n;
	logic [16:0]   noise_value;

	vnf_ctrl #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.oct_n    (oct_n),
		.cmd      (cmd)
	);

	vnf_datapath #(
		.MAX_OCTAVES(MAX_OCTAVES),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.pos_x       (s_tdata[31:0]),
		.pos_y       (s_tdata[63:32]),
		.pos_z       (s_tdata[95:64]),
		.cmd         (cmd),
		.oct_n       (oct_n),
		.noise_value (noise_value)
	);

	assign m_tdata = {7'd0, noise_value};

	// checks
	`VNF_ASSERT_IMP(a_out_range, m_tvalid, m_tdata[16:0] <= 17'd65536)
	`VNF_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`VNF_ASSERT_IMP(a_idle_on_result, $rose(m_tvalid), s_tready)

endmodule

`default_nettype wire

### design/vnf_datapath.sv
// ----------------------------------------------------------------------------
// vnf_datapath
// Registers, shared multiplier, hash, blend, accumulate and divide logic.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_datapath #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [vnf_pkg::CFG_AW-1:0]    cfg_addr,
	input  wire [vnf_pkg::CFG_DW-1:0]    cfg_wdata,
	input  wire signed [31:0]            pos_x,
	input  wire signed [31:0]            pos_y,
	input  wire signed [31:0]            pos_z,
	input  vnf_pkg::cmd_t                cmd,
	output logic [$clog2(MAX_OCTAVES+1)-1:0] oct_n,
	output logic [16:0]                  noise_value
);
	import vnf_pkg::*;

	localparam int OB = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
	localparam int TW = 17 + OB;
	localparam int DW = div_width(MAX_OCTAVES);
	localparam int RW = TW + 2;
	localparam int OW = $clog2(MAX_OCTAVES+1);

	// configuration registers
	logic [3:0]         oct_cfg_q;
	logic [15:0]        pers_q;
	logic signed [30:0] offx_q, offy_q, offz_q;

	// working registers
	logic signed [32:0] p_q [3];
	logic [31:0]        cell_q [3];
	logic [15:0]        t_q [3];
	logic [16:0]        w_q [3];
	logic [31:0]        tt_q;
	logic [31:0]        n_q, m_q;
	logic signed [17:0] cv_q [8];
	logic signed [17:0] ax_q [4];
	logic signed [17:0] bz_q [2];
	logic signed [17:0] nz_q;
	logic signed [DW-1:0] sum_q;
	logic [TW-1:0]      tot_q;
	logic [16:0]        amp_q;
	logic [DW-1:0]      dvd_q;
	logic [RW-1:0]      rem_q;
	logic [16:0]        res_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cfg_q <= OCT_DEFAULT[3:0];
			pers_q    <= 16'd32768;
			offx_q    <= '0;
			offy_q    <= '0;
			offz_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_OCTAVE_COUNT: oct_cfg_q <= cfg_wdata[3:0];
				REG_PERSISTENCE:  pers_q    <= cfg_wdata[15:0];
				REG_OFFSET_X:     offx_q    <= cfg_wdata[30:0];
				REG_OFFSET_Y:     offy_q    <= cfg_wdata[30:0];
				REG_OFFSET_Z:     offz_q    <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// octave count clamped to 1..MAX_OCTAVES
	always_comb begin
		if (oct_cfg_q == 4'd0)
			oct_n = OW'(1);
		else if ({1'b0, oct_cfg_q} > 5'(MAX_OCTAVES))
			oct_n = OW'(MAX_OCTAVES);
		else
			oct_n = OW'(oct_cfg_q);
	end

	// per-axis split: cell index and Q0.16 fraction
	logic signed [63:0] ext [3];
	logic [31:0]        cell_d [3];
	logic [FRAC_BITS+15:0] tw [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ext[a]    = {{31{p_q[a][32]}}, p_q[a]} << cmd.shift;
			cell_d[a] = ext[a][FRAC_BITS+31:FRAC_BITS];
			tw[a]     = {ext[a][FRAC_BITS-1:0], 16'h0000} >> FRAC_BITS;
		end
	end

	// axis / level selected operands
	logic [15:0]        t_sel;
	logic [16:0]        w_sel;
	logic signed [17:0] la, lb;
	always_comb begin
		case (cmd.sel[1:0])
			2'd0:    begin t_sel = t_q[0]; w_sel = w_q[0]; la = cv_q[0]; lb = cv_q[1]; end
			2'd1:    begin t_sel = t_q[1]; w_sel = w_q[1]; la = ax_q[0]; lb = ax_q[1]; end
			2'd2:    begin t_sel = t_q[2]; w_sel = w_q[2]; la = bz_q[0]; lb = bz_q[1]; end
			default: begin t_sel = t_q[0]; w_sel = w_q[0]; la = cv_q[0]; lb = cv_q[1]; end
		endcase
	end

	// corner hash seed
	logic [31:0] cx, cy, cz, n0, nx;
	always_comb begin
		cx = cmd.sel[0] ? cell_q[0] + 32'd1 : cell_q[0];
		cy = cmd.sel[1] ? cell_q[1] + 32'd1 : cell_q[1];
		cz = cmd.sel[2] ? cell_q[2] + 32'd1 : cell_q[2];
		n0 = cx + cy * HASH_MUL_Y + cz * HASH_MUL_Z;
		nx = (n0 << 13) ^ n0;
	end

	// shared multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	logic [17:0]        sm_k;
	logic signed [18:0] diff;
	always_comb begin
		sm_k = 18'd196608 - {1'b0, t_sel, 1'b0};
		diff = {lb[17], lb} - {la[17], la};
		case (cmd.op)
			OP_SQ:     begin ma = {17'd0, t_sel};       mb = {17'd0, t_sel}; end
			OP_SMOOTH: begin ma = {1'b0, tt_q};         mb = {15'd0, sm_k}; end
			OP_H1:     begin ma = {1'b0, n_q};          mb = {1'b0, n_q}; end
			OP_H2:     begin ma = {1'b0, m_q};          mb = {1'b0, HASH_K1}; end
			OP_H3:     begin ma = {1'b0, n_q};          mb = {1'b0, m_q}; end
			OP_LERP:   begin ma = {{14{diff[18]}}, diff}; mb = {16'd0, w_sel}; end
			OP_ACC:    begin ma = {{15{nz_q[17]}}, nz_q}; mb = {16'd0, amp_q}; end
			OP_AMP:    begin ma = {16'd0, amp_q};       mb = {17'd0, pers_q}; end
			default:   begin ma = '0;                   mb = '0; end
		endcase
		prod = ma * mb;
	end

	// post-multiply results
	logic [49:0]        sp;
	logic [30:0]        hv;
	logic [31:0]        hr;
	logic signed [17:0] cv_new;
	logic signed [36:0] lv, lsh;
	logic signed [17:0] lr;
	logic [33:0]        ar;
	logic [TW:0]        dsr;
	logic [RW-1:0]      rs;
	logic               ge;
	always_comb begin
		sp     = prod[49:0] + 50'h0_8000_0000;
		hv     = 31'(prod[31:0] + HASH_K3);
		hr     = {1'b0, hv} + 32'd8192;
		cv_new = 18'(ONE_Q16) - 18'(hr[31:14]);
		lv     = prod[36:0] + 37'sd32768;
		lsh    = lv >>> 16;
		lr     = la + lsh[17:0];
		ar     = prod[33:0] + 34'd32768;
		dsr    = {tot_q, 1'b0};
		rs     = {rem_q[RW-2:0], dvd_q[DW-1]};
		ge     = rs >= RW'(dsr);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				p_q[0] <= {pos_x[31], pos_x} + {{2{offx_q[30]}}, offx_q};
				p_q[1] <= {pos_y[31], pos_y} + {{2{offy_q[30]}}, offy_q};
				p_q[2] <= {pos_z[31], pos_z} + {{2{offz_q[30]}}, offz_q};
				sum_q  <= '0;
				tot_q  <= '0;
				amp_q  <= ONE_Q16;
			end
			OP_SPLIT: begin
				for (int a = 0; a < 3; a++) begin
					cell_q[a] <= cell_d[a];
					t_q[a]    <= tw[a][15:0];
				end
			end
			OP_SQ:     tt_q <= prod[31:0];
			OP_SMOOTH: begin
				case (cmd.sel[1:0])
					2'd0:    w_q[0] <= sp[48:32];
					2'd1:    w_q[1] <= sp[48:32];
					default: w_q[2] <= sp[48:32];
				endcase
			end
			OP_H0: n_q <= nx;
			OP_H1: m_q <= prod[31:0];
			OP_H2: m_q <= prod[31:0] + HASH_K2;
			OP_H3: begin
				for (int i = 0; i < 7; i++)
					cv_q[i] <= cv_q[i+1];
				cv_q[7] <= cv_new;
			end
			OP_LERP: begin
				case (cmd.sel[1:0])
					2'd0: begin
						for (int i = 0; i < 6; i++)
							cv_q[i] <= cv_q[i+2];
						for (int i = 0; i < 3; i++)
							ax_q[i] <= ax_q[i+1];
						ax_q[3] <= lr;
					end
					2'd1: begin
						ax_q[0] <= ax_q[2];
						ax_q[1] <= ax_q[3];
						bz_q[0] <= bz_q[1];
						bz_q[1] <= lr;
					end
					default: nz_q <= lr;
				endcase
			end
			OP_ACC: begin
				sum_q <= sum_q + prod[DW-1:0];
				tot_q <= tot_q + TW'(amp_q);
			end
			OP_AMP:   amp_q <= ar[32:16];
			OP_DINIT: begin
				dvd_q <= sum_q + DW'({tot_q, 16'h0000}) + DW'(tot_q);
				rem_q <= '0;
			end
			OP_DSTEP: begin
				rem_q <= ge ? rs - RW'(dsr) : rs;
				dvd_q <= {dvd_q[DW-2:0], ge};
			end
			OP_OUT: res_q <= (dvd_q > DW'(ONE_Q16)) ? ONE_Q16 : dvd_q[16:0];
			default: ;
		endcase
	end

	assign noise_value = res_q;

endmodule

`default_nettype wire

### design/vnf_ctrl.sv
// ----------------------------------------------------------------------------
// vnf_ctrl
// Sequencer: steps the datapath through octaves, corners, blends and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_ctrl #(
	parameter int MAX_OCTAVES = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	input  wire [$clog2(MAX_OCTAVES+1)-1:0]  oct_n,
	output vnf_pkg::cmd_t                    cmd
);
	import vnf_pkg::*;

	localparam int OW = $clog2(MAX_OCTAVES+1);
	localparam int DW = div_width(MAX_OCTAVES);
	localparam int CW = $clog2(DW);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SPLIT  = 4'd1;
	localparam logic [3:0] S_SQ     = 4'd2;
	localparam logic [3:0] S_SMOOTH = 4'd3;
	localparam logic [3:0] S_H0     = 4'd4;
	localparam logic [3:0] S_H1     = 4'd5;
	localparam logic [3:0] S_H2     = 4'd6;
	localparam logic [3:0] S_H3     = 4'd7;
	localparam logic [3:0] S_LERP   = 4'd8;
	localparam logic [3:0] S_ACC    = 4'd9;
	localparam logic [3:0] S_AMP    = 4'd10;
	localparam logic [3:0] S_DINIT  = 4'd11;
	localparam logic [3:0] S_DIV    = 4'd12;
	localparam logic [3:0] S_OUT    = 4'd13;

	logic [3:0]    state_q;
	logic [OW-1:0] oct_q;
	logic [2:0]    cnt_q;
	logic [CW-1:0] div_q;
	logic          mvalid_q;
	logic          out_free;
	logic [2:0]    level;

	assign out_free = !mvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mvalid_q;

	// blend level: four x blends, two y blends, one z blend
	always_comb begin
		if (cnt_q < 3'd4)
			level = 3'd0;
		else if (cnt_q < 3'd6)
			level = 3'd1;
		else
			level = 3'd2;
	end

	// command decode
	always_comb begin
		cmd.op    = OP_NOP;
		cmd.sel   = cnt_q;
		cmd.shift = 4'(oct_q);
		case (state_q)
			S_IDLE:   cmd.op = s_tvalid ? OP_LOAD : OP_NOP;
			S_SPLIT:  cmd.op = OP_SPLIT;
			S_SQ:     cmd.op = OP_SQ;
			S_SMOOTH: cmd.op = OP_SMOOTH;
			S_H0:     cmd.op = OP_H0;
			S_H1:     cmd.op = OP_H1;
			S_H2:     cmd.op = OP_H2;
			S_H3:     cmd.op = OP_H3;
			S_LERP:   begin cmd.op = OP_LERP; cmd.sel = level; end
			S_ACC:    cmd.op = OP_ACC;
			S_AMP:    cmd.op = OP_AMP;
			S_DINIT:  cmd.op = OP_DINIT;
			S_DIV:    cmd.op = OP_DSTEP;
			S_OUT:    cmd.op = out_free ? OP_OUT : OP_NOP;
			default:  cmd.op = OP_NOP;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			oct_q    <= '0;
			cnt_q    <= '0;
			div_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			// result valid: set on a new result, cleared when taken
			if (state_q == S_OUT && out_free)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						oct_q   <= '0;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: state_q <= S_SMOOTH;
				S_SMOOTH: begin
					if (cnt_q == 3'd2) begin
						cnt_q   <= '0;
						state_q <= S_H0;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_SQ;
					end
				end
				S_H0: state_q <= S_H1;
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: begin
					cnt_q   <= cnt_q + 3'd1;
					state_q <= (cnt_q == 3'd7) ? S_LERP : S_H0;
				end
				S_LERP: begin
					if (cnt_q == 3'd6) begin
						cnt_q   <= '0;
						state_q <= S_ACC;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_ACC: state_q <= S_AMP;
				S_AMP: begin
					if (oct_q == OW'(oct_n - 1'b1)) begin
						state_q <= S_DINIT;
					end else begin
						oct_q   <= oct_q + 1'b1;
						state_q <= S_SPLIT;
					end
				end
				S_DINIT: begin
					div_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_q <= div_q + 1'b1;
					if (div_q == CW'(DW - 1))
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
